// ----- design/aspc_pkg.sv -----
// ----------------------------------------------------------------------------
// aspc_pkg
// Shared widths, types and codes for the aliquot sum / perfect number checker.
// ----------------------------------------------------------------------------
package aspc_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int SUM_WIDTH   = 18;
   // accumulator headroom: aliquot sum stays below 16 * value for 16-bit values
   localparam int ACC_WIDTH   = (VALUE_WIDTH + 4 > SUM_WIDTH + 1) ?
                                (VALUE_WIDTH + 4) : (SUM_WIDTH + 1);
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
   localparam int REQ_DATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((SUM_WIDTH + 1 + 7) / 8) * 8;

   localparam logic [ACC_WIDTH-1:0] SUM_MAX =
      {{(ACC_WIDTH - SUM_WIDTH){1'b0}}, {SUM_WIDTH{1'b1}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                   start;
      logic [VALUE_WIDTH-1:0] dividend;
      logic [VALUE_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } div_rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [SUM_WIDTH-1:0] divisor_sum;
      logic                 is_perfect;
   } result_type;

endpackage

// ----- design/aspc_divider.sv -----
// ----------------------------------------------------------------------------
// aspc_divider
// Restoring divider, one quotient bit per cycle; reports whether the
// remainder is zero.
// ----------------------------------------------------------------------------
module aspc_divider
   import aspc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                   busy_ff,  busy_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [VALUE_WIDTH-1:0] rem_ff,   rem_in;
   logic [VALUE_WIDTH-1:0] dvd_ff,   dvd_in;
   logic [VALUE_WIDTH-1:0] dsr_ff,   dsr_in;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;

   assign trial = {rem_ff, dvd_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      div_rsp  = '0;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = CNT_WIDTH'(VALUE_WIDTH);
         rem_in   = '0;
         dvd_in   = div_req.dividend;
         dsr_in   = div_req.divisor;
      end else if (busy_ff) begin
         if (count_ff == '0) begin
            busy_in          = 1'b0;
            div_rsp.done     = 1'b1;
            div_rsp.rem_zero = (rem_ff == '0);
         end else begin
            // remainder always below divisor, so it fits back in VALUE_WIDTH
            if (!diff[VALUE_WIDTH]) begin
               rem_in = diff[VALUE_WIDTH-1:0];
            end else begin
               rem_in = trial[VALUE_WIDTH-1:0];
            end
            dvd_in   = {dvd_ff[VALUE_WIDTH-2:0], 1'b0};
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

endmodule

// ----- design/aspc_ctrl.sv -----
// ----------------------------------------------------------------------------
// aspc_ctrl
// Sequencer: walks candidates 1 .. n-1 through the shared divider and
// accumulates the ones that divide n evenly.
// ----------------------------------------------------------------------------
module aspc_ctrl
   import aspc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [VALUE_WIDTH-1:0] in_value,
   output div_req_type            div_req,
   input  div_rsp_type            div_rsp,
   output result_type             result,
   input  logic                   result_take
);

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] n_ff,     n_in;
   logic [VALUE_WIDTH-1:0] d_ff,     d_in;
   logic [ACC_WIDTH-1:0]   acc_ff,   acc_in;
   logic [VALUE_WIDTH-1:0] last_d;

   assign last_d = n_ff - 1'b1;

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      acc_in   = acc_ff;
      in_ready = 1'b0;
      div_req  = '{start: 1'b0, dividend: n_ff, divisor: d_ff};
      result.valid       = 1'b0;
      result.divisor_sum = (acc_ff > SUM_MAX) ? SUM_MAX[SUM_WIDTH-1:0]
                                              : acc_ff[SUM_WIDTH-1:0];
      result.is_perfect  = (n_ff != '0) &&
                           (acc_ff == {{(ACC_WIDTH - VALUE_WIDTH){1'b0}}, n_ff});
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               n_in   = in_value;
               d_in   = {{(VALUE_WIDTH - 1){1'b0}}, 1'b1};
               acc_in = '0;
               // zero and one have no proper divisors to test
               if (in_value[VALUE_WIDTH-1:1] == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            div_req.start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.rem_zero) begin
                  acc_in = acc_ff + {{(ACC_WIDTH - VALUE_WIDTH){1'b0}}, d_ff};
               end
               if (d_ff == last_d) begin
                  state_in = ST_DONE;
               end else begin
                  d_in     = d_ff + 1'b1;
                  state_in = ST_START;
               end
            end
         end
         ST_DONE: begin
            result.valid = 1'b1;
            if (result_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      n_ff   <= n_in;
      d_ff   <= d_in;
      acc_ff <= acc_in;
   end

endmodule

// ----- design/aliquot_sum_perfect_check.sv -----
// ----------------------------------------------------------------------------
// aliquot_sum_perfect_check
// Aliquot sum (sum of proper divisors) of an unsigned number by trial
// division, with a perfect-number flag.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | tdata fields (low bit up)
//  --------+-----+---------------------+-----------------------------------
//  req     | in  | req_tvalid/tready   | value[15:0]
//  rsp     | out | rsp_tvalid/tready   | divisor_sum[17:0], is_perfect[18]
//
//  Run time grows with n: the single restoring divider tests one candidate
//  divisor per pass, one quotient bit per cycle, with a start step and a
//  finish step per pass. Values 0 and 1 skip the divider.
//  One item is in work at a time; req_tready is low until the sequencer
//  is idle again. The result sits in an output register, so the next
//  transfer can be taken while rsp is stalled.
//  Reset: synchronous, active high; clears sequencer and output valid.
// ----------------------------------------------------------------------------
module aliquot_sum_perfect_check
   import aspc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // divisor_sum, is_perfect, pad
);

   div_req_type div_req;
   div_rsp_type div_rsp;
   result_type  result;
   logic        out_free;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff,  rsp_data_in;

   // output register empty, or emptied by a transfer this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   aspc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_value    (req_tdata[VALUE_WIDTH-1:0]),   // any upper pad bits are ignored
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .result      (result),
      .result_take (out_free)
   );

   aspc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = result.valid;
         if (result.valid) begin
            rsp_data_in = {{(RSP_DATA_W - SUM_WIDTH - 1){1'b0}},
                           result.is_perfect, result.divisor_sum};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // one item at a time: no second transfer right after an accepted one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted twice in a row");

   // a finished result waits in the sequencer until the output register frees
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      result.valid && !out_free |=> result.valid)
      else $error("result dropped while output register full");

   // output register only fills from a finished result
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(result.valid))
      else $error("rsp_tvalid without a finished result");

   // the sequencer never accepts input while its own result is pending
   a_idle_excl: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> !req_tready)
      else $error("ready while result pending");

endmodule
